// ===== src/dipole_screened_boundary_potential_assert.svh =====
// Assertion macros used by the checker file.
`ifndef DIPOLE_SCREENED_BOUNDARY_POTENTIAL_ASSERT_SVH
`define DIPOLE_SCREENED_BOUNDARY_POTENTIAL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DSBP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dsbp: assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DSBP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dsbp: assertion failed");

`endif

// ===== src/dsbp_pkg.sv =====
package dsbp_pkg;

	localparam int PT_W      = 10;
	localparam int COORD_W   = 21;
	localparam int AXES      = 3;
	localparam int CTR_W     = AXES * COORD_W;
	localparam int COEF_W    = 32;
	localparam int DECAY_W   = 32;
	localparam int CFG_W     = 63;
	localparam int IDX_W     = 3;
	localparam int P_SHIFT   = 10;
	localparam int D_W       = COORD_W + 1;
	localparam int SQ_W      = 44;
	localparam int RAD_SHIFT = 12;
	localparam int RAD_W     = SQ_W + RAD_SHIFT;
	localparam int R_W       = RAD_W / 2;
	localparam int X_W       = R_W + DECAY_W;
	localparam int X_SHIFT   = 8;
	localparam int XS_W      = 37;
	localparam int LOG2E_W   = 25;
	localparam int PROD_W    = XS_W + LOG2E_W;
	localparam int Y_SHIFT   = 24;
	localparam int F_W       = 32;
	localparam int N_W       = PROD_W - Y_SHIFT - F_W;
	localparam int E_W       = F_W + 1;
	localparam int PM_W      = E_W + F_W;
	localparam int EXP_BITS  = 24;
	localparam int NUM_W     = 64;
	localparam int DIV_SHIFT = 16;
	localparam int QD_W      = NUM_W - DIV_SHIFT;
	localparam int TERM_W    = QD_W + 2;
	localparam int SUM_W     = TERM_W + 1;
	localparam int POT_W     = 32;

	localparam logic [LOG2E_W-1:0] LOG2E_Q24 = LOG2E_W'(24204406);
	localparam logic [X_W-1:0]     X_LIMIT   = X_W'(23) << 40;
	localparam logic [N_W-1:0]     N_LIMIT   = N_W'(33);
	localparam logic [E_W-1:0]     E_ONE     = E_W'(1) << F_W;

	localparam logic signed [TERM_W-1:0] TERM_RAIL = TERM_W'(1) << (POT_W - 1);
	localparam logic signed [SUM_W-1:0]  POT_MAX   = (SUM_W'(1) << (POT_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0]  POT_MIN   = ~POT_MAX;

	typedef enum logic [IDX_W-1:0] {
		REG_PLUS_COEF    = 3'd0,
		REG_MINUS_COEF   = 3'd1,
		REG_PLUS_CENTER  = 3'd2,
		REG_MINUS_CENTER = 3'd3,
		REG_DECAY_RATE   = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [PT_W-1:0] point_x;
		logic [PT_W-1:0] point_y;
		logic [PT_W-1:0] point_z;
	} in_word_t;

	typedef struct packed {
		logic signed [POT_W-1:0] potential;
		logic                    saturated;
	} out_word_t;

	typedef struct packed {
		logic           big;
		logic [N_W-1:0] n;
		logic [F_W-1:0] frac;
		logic [R_W-1:0] root;
	} exp_side_t;

	typedef logic [EXP_BITS:1][F_W-1:0] exp_tab_t;

	function automatic logic [63:0] c_isqrt(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitv;
		rem  = v;
		res  = '0;
		bitv = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bitv) begin
				rem = rem - res - bitv;
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic exp_tab_t gen_exp_tab();
		exp_tab_t    tab;
		logic [63:0] v;
		v = 64'h8000_0000_0000_0000;
		tab[1] = F_W'(c_isqrt(v));
		for (int i = 2; i <= EXP_BITS; i++) begin
			v = {tab[i-1], 32'h0};
			tab[i] = F_W'(c_isqrt(v));
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = gen_exp_tab();

endpackage

// ===== src/dsbp_sqrt.sv =====
module dsbp_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [dsbp_pkg::RAD_W-1:0] rad,
	output logic                       out_vld,
	output logic [dsbp_pkg::R_W-1:0]   root
);
	import dsbp_pkg::*;

	logic [R_W-1:0] vld_s;
	logic [RAD_W:0] rem_s   [R_W];
	logic [R_W-1:0] root_s  [R_W];
	logic [RAD_W:0] rem_nx  [R_W];
	logic [R_W-1:0] root_nx [R_W];

	always_comb begin
		logic [RAD_W:0] r_in;
		logic [RAD_W:0] t;
		logic [R_W-1:0] q_in;
		for (int k = 0; k < R_W; k++) begin
			if (k == 0) begin
				r_in = {1'b0, rad};
				q_in = '0;
			end else begin
				r_in = rem_s[k-1];
				q_in = root_s[k-1];
			end
			t = ((RAD_W+1)'(q_in) << (R_W - k)) | ((RAD_W+1)'(1) << (2 * (R_W - 1 - k)));
			if (r_in >= t) begin
				rem_nx[k]  = r_in - t;
				root_nx[k] = q_in | (R_W'(1) << (R_W - 1 - k));
			end else begin
				rem_nx[k]  = r_in;
				root_nx[k] = q_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[R_W-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s  <= rem_nx;
			root_s <= root_nx;
		end
	end

	assign out_vld = vld_s[R_W-1];
	assign root    = root_s[R_W-1];

endmodule

// ===== src/dsbp_exp.sv =====
module dsbp_exp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_vld,
	input  logic [dsbp_pkg::X_W-1:0] x,
	input  logic [dsbp_pkg::R_W-1:0] root_in,
	output logic                     out_vld,
	output logic [dsbp_pkg::E_W-1:0] e,
	output logic [dsbp_pkg::R_W-1:0] root_out
);
	import dsbp_pkg::*;

	localparam int STAGES = EXP_BITS + 3;

	logic [STAGES-1:0]  vld_s;
	logic [PROD_W-1:0]  prod_s1;
	logic               big_s1;
	logic [R_W-1:0]     root_s1;
	logic [E_W-1:0]     e_c     [EXP_BITS+1];
	exp_side_t          side_c  [EXP_BITS+1];
	logic [E_W-1:0]     e_nx    [EXP_BITS+1];
	exp_side_t          side_nx [EXP_BITS+1];
	logic [E_W-1:0]     e_f_q;
	logic [R_W-1:0]     root_f_q;
	logic [XS_W-1:0]    xs;

	assign xs = x[X_SHIFT +: XS_W];

	always_comb begin
		logic [PM_W-1:0] pm;
		side_nx[0].big  = big_s1;
		side_nx[0].n    = prod_s1[PROD_W-1 -: N_W];
		side_nx[0].frac = prod_s1[Y_SHIFT +: F_W];
		side_nx[0].root = root_s1;
		e_nx[0]         = E_ONE;
		for (int k = 1; k <= EXP_BITS; k++) begin
			pm = PM_W'(e_c[k-1]) * PM_W'(EXP_TAB[k]);
			side_nx[k] = side_c[k-1];
			e_nx[k]    = side_c[k-1].frac[F_W-k] ? pm[F_W +: E_W] : e_c[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[STAGES-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= PROD_W'(xs) * PROD_W'(LOG2E_Q24);
			big_s1   <= (x >= X_LIMIT);
			root_s1  <= root_in;
			e_c      <= e_nx;
			side_c   <= side_nx;
			root_f_q <= side_c[EXP_BITS].root;
			if (side_c[EXP_BITS].big || side_c[EXP_BITS].n >= N_LIMIT) begin
				e_f_q <= '0;
			end else begin
				e_f_q <= e_c[EXP_BITS] >> side_c[EXP_BITS].n;
			end
		end
	end

	assign out_vld  = vld_s[STAGES-1];
	assign e        = e_f_q;
	assign root_out = root_f_q;

endmodule

// ===== src/dsbp_div.sv =====
module dsbp_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [dsbp_pkg::QD_W-1:0] dividend,
	input  logic [dsbp_pkg::R_W-1:0]  divisor,
	input  logic                      zero_in,
	output logic                      out_vld,
	output logic [dsbp_pkg::QD_W-1:0] quot,
	output logic                      zero_out
);
	import dsbp_pkg::*;

	logic [QD_W-1:0] vld_s;
	logic [QD_W-1:0] zero_s;
	logic [R_W-1:0]  rem_s  [QD_W];
	logic [QD_W-1:0] num_s  [QD_W];
	logic [R_W-1:0]  dv_s   [QD_W];
	logic [QD_W-1:0] q_s    [QD_W];
	logic [R_W-1:0]  rem_nx [QD_W];
	logic [QD_W-1:0] num_nx [QD_W];
	logic [R_W-1:0]  dv_nx  [QD_W];
	logic [QD_W-1:0] q_nx   [QD_W];

	always_comb begin
		logic [R_W-1:0]  r_in;
		logic [QD_W-1:0] n_in;
		logic [R_W-1:0]  d_in;
		logic [QD_W-1:0] q_in;
		logic [R_W:0]    rr;
		for (int k = 0; k < QD_W; k++) begin
			if (k == 0) begin
				r_in = '0;
				n_in = dividend;
				d_in = divisor;
				q_in = '0;
			end else begin
				r_in = rem_s[k-1];
				n_in = num_s[k-1];
				d_in = dv_s[k-1];
				q_in = q_s[k-1];
			end
			rr = {r_in, n_in[QD_W-1-k]};
			num_nx[k] = n_in;
			dv_nx[k]  = d_in;
			if (rr >= {1'b0, d_in}) begin
				rem_nx[k] = R_W'(rr - {1'b0, d_in});
				q_nx[k]   = q_in | (QD_W'(1) << (QD_W - 1 - k));
			end else begin
				rem_nx[k] = R_W'(rr);
				q_nx[k]   = q_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QD_W-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s <= {zero_s[QD_W-2:0], zero_in};
			rem_s  <= rem_nx;
			num_s  <= num_nx;
			dv_s   <= dv_nx;
			q_s    <= q_nx;
		end
	end

	assign out_vld  = vld_s[QD_W-1];
	assign quot     = q_s[QD_W-1];
	assign zero_out = zero_s[QD_W-1];

endmodule

// ===== src/dsbp_term.sv =====
module dsbp_term (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_vld,
	input  dsbp_pkg::in_word_t                  point,
	input  logic signed [dsbp_pkg::COEF_W-1:0]  coef,
	input  logic [dsbp_pkg::CTR_W-1:0]          center,
	input  logic [dsbp_pkg::DECAY_W-1:0]        decay,
	output logic                                out_vld,
	output logic signed [dsbp_pkg::TERM_W-1:0]  term,
	output logic                                zero
);
	import dsbp_pkg::*;

	logic [AXES-1:0][PT_W-1:0] pt;
	logic [SQ_W-1:0]           sq_nx [AXES];
	logic [SQ_W-1:0]           sq_s1 [AXES];
	logic                      vld_s1;
	logic [RAD_W-1:0]          rad_s2;
	logic                      vld_s2;
	logic                      sq_vld;
	logic [R_W-1:0]            sq_root;
	logic [X_W-1:0]            x_s3;
	logic [R_W-1:0]            root_s3;
	logic                      vld_s3;
	logic                      ex_vld;
	logic [E_W-1:0]            ex_e;
	logic [R_W-1:0]            ex_root;
	logic [COEF_W-1:0]         mag;
	logic [NUM_W-1:0]          num_s4;
	logic [R_W-1:0]            root_s4;
	logic                      vld_s4;
	logic                      dv_vld;
	logic [QD_W-1:0]           dv_quot;
	logic                      dv_zero;
	logic signed [TERM_W-1:0]  term_s5;
	logic                      zero_s5;
	logic                      vld_s5;
	logic signed [TERM_W-1:0]  quot_ext;

	assign pt  = {point.point_z, point.point_y, point.point_x};
	assign mag = coef[COEF_W-1] ? COEF_W'(-coef) : COEF_W'(coef);

	always_comb begin
		logic signed [D_W-1:0]  d;
		logic signed [SQ_W-1:0] dx;
		for (int k = 0; k < AXES; k++) begin
			d  = $signed({1'b0, center[k*COORD_W +: COORD_W]})
				- $signed(D_W'({pt[k], P_SHIFT'(0)}));
			dx = SQ_W'(d);
			sq_nx[k] = SQ_W'(dx * dx);
		end
	end

	dsbp_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.rad     (rad_s2),
		.out_vld (sq_vld),
		.root    (sq_root)
	);

	dsbp_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.x        (x_s3),
		.root_in  (root_s3),
		.out_vld  (ex_vld),
		.e        (ex_e),
		.root_out (ex_root)
	);

	dsbp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.dividend (num_s4[NUM_W-1 -: QD_W]),
		.divisor  (root_s4),
		.zero_in  (root_s4 == '0),
		.out_vld  (dv_vld),
		.quot     (dv_quot),
		.zero_out (dv_zero)
	);

	assign quot_ext = $signed({2'b00, dv_quot});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= sq_vld;
			vld_s4 <= ex_vld;
			vld_s5 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1   <= sq_nx;
			rad_s2  <= {sq_s1[0] + sq_s1[1] + sq_s1[2], RAD_SHIFT'(0)};
			x_s3    <= X_W'(sq_root) * X_W'(decay);
			root_s3 <= sq_root;
			num_s4  <= NUM_W'(mag) * NUM_W'(ex_e);
			root_s4 <= ex_root;
			zero_s5 <= dv_zero;
			if (dv_zero) begin
				if (coef == '0) begin
					term_s5 <= '0;
				end else if (coef[COEF_W-1]) begin
					term_s5 <= -TERM_RAIL;
				end else begin
					term_s5 <= TERM_RAIL;
				end
			end else if (coef[COEF_W-1]) begin
				term_s5 <= -quot_ext;
			end else begin
				term_s5 <= quot_ext;
			end
		end
	end

	assign out_vld = vld_s5;
	assign term    = term_s5;
	assign zero    = zero_s5;

endmodule

// ===== src/dipole_screened_boundary_potential.sv =====
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output register is full and stalled.
// Reset: arst_n clears all valid bits and the five configuration registers
// to zero; pipeline data registers are not reset.
module dipole_screened_boundary_potential (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  dsbp_pkg::in_word_t          in_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output dsbp_pkg::out_word_t         out_word,
	input  logic                        cfg_we,
	input  logic [dsbp_pkg::IDX_W-1:0]  cfg_index,
	input  logic [dsbp_pkg::CFG_W-1:0]  cfg_data
);
	import dsbp_pkg::*;

	logic signed [COEF_W-1:0] plus_coef_q;
	logic signed [COEF_W-1:0] minus_coef_q;
	logic [CTR_W-1:0]         plus_center_q;
	logic [CTR_W-1:0]         minus_center_q;
	logic [DECAY_W-1:0]       decay_rate_q;
	logic                     en;
	logic                     p_vld;
	logic signed [TERM_W-1:0] p_term;
	logic                     p_zero;
	logic                     m_vld;
	logic signed [TERM_W-1:0] m_term;
	logic                     m_zero;
	logic signed [SUM_W-1:0]  sum;
	logic                     out_vld_q;
	out_word_t                out_word_q;

	assign en       = !out_vld_q || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plus_coef_q    <= '0;
			minus_coef_q   <= '0;
			plus_center_q  <= '0;
			minus_center_q <= '0;
			decay_rate_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PLUS_COEF:    plus_coef_q    <= cfg_data[COEF_W-1:0];
				REG_MINUS_COEF:   minus_coef_q   <= cfg_data[COEF_W-1:0];
				REG_PLUS_CENTER:  plus_center_q  <= cfg_data[CTR_W-1:0];
				REG_MINUS_CENTER: minus_center_q <= cfg_data[CTR_W-1:0];
				REG_DECAY_RATE:   decay_rate_q   <= cfg_data[DECAY_W-1:0];
				default: ;
			endcase
		end
	end

	dsbp_term u_plus (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.point   (in_word),
		.coef    (plus_coef_q),
		.center  (plus_center_q),
		.decay   (decay_rate_q),
		.out_vld (p_vld),
		.term    (p_term),
		.zero    (p_zero)
	);

	dsbp_term u_minus (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.point   (in_word),
		.coef    (minus_coef_q),
		.center  (minus_center_q),
		.decay   (decay_rate_q),
		.out_vld (m_vld),
		.term    (m_term),
		.zero    (m_zero)
	);

	assign sum = SUM_W'(p_term) + SUM_W'(m_term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= p_vld && m_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sum > POT_MAX) begin
				out_word_q.potential <= POT_W'(POT_MAX);
				out_word_q.saturated <= 1'b1;
			end else if (sum < POT_MIN) begin
				out_word_q.potential <= POT_W'(POT_MIN);
				out_word_q.saturated <= 1'b1;
			end else begin
				out_word_q.potential <= POT_W'(sum);
				out_word_q.saturated <= p_zero || m_zero;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_word  = out_word_q;

endmodule

// ===== src/dsbp_checker.sv =====
`include "dipole_screened_boundary_potential_assert.svh"

module dsbp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input dsbp_pkg::out_word_t  out_word
);
	import dsbp_pkg::*;

	`DSBP_ASSERT_IMP(a_stall_tracks_out, in_valid || !in_valid, in_stall == (out_valid && out_stall))
	`DSBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
	`DSBP_ASSERT_IMP(a_out_rise_on_advance, $rose(out_valid), $past(!in_stall))

endmodule

bind dipole_screened_boundary_potential dsbp_checker u_dsbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import dsbp_pkg::*;

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t res;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_stall;
	out_word_t out_word;
	logic      cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	logic signed [31:0] plus_coef_r, minus_coef_r;
	logic [62:0]        plus_center_r, minus_center_r;
	logic [31:0]        decay_r;
	longint unsigned    half_root [1:EXP_BITS];

	out_word_t pending_q[$];
	int        mismatches;
	bit        calm;
	int        out_hold;

	dipole_screened_boundary_potential dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned screen_factor(longint unsigned x);
		longint unsigned y, f, e;
		longint unsigned n;
		if (x >= (64'd23 << 40))
			return 0;
		y = ((x >> 8) * 64'd24204406) >> 24;
		n = y >> 32;
		f = y & 64'hFFFF_FFFF;
		e = 64'h1_0000_0000;
		for (int i = 1; i <= EXP_BITS; i++)
			if (f[32-i])
				e = (e * half_root[i]) >> 32;
		if (n >= 33)
			return 0;
		return e >> n;
	endfunction

	function automatic longint charge_potential(logic signed [31:0] coef, logic [62:0] center,
			in_word_t p, output bit zero);
		longint          cf, c, q, d;
		longint unsigned s, r, e, mag;
		logic [9:0]      pc [3];
		pc[0] = p.point_x;
		pc[1] = p.point_y;
		pc[2] = p.point_z;
		cf = coef;
		s = 0;
		zero = 0;
		for (int k = 0; k < 3; k++) begin
			c = longint'(center[21*k +: 21]);
			q = longint'(pc[k]) * 1024;
			d = c - q;
			s += d * d;
		end
		r = int_root(s << 12);
		if (r == 0) begin
			zero = 1;
			if (cf == 0)
				return 0;
			return cf > 0 ? 64'sh8000_0000 : -64'sh8000_0000;
		end
		e = screen_factor(r * longint'(decay_r));
		mag = cf < 0 ? -cf : cf;
		mag = (mag * e) / (r << 16);
		return cf < 0 ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic out_word_t dipole_potential(in_word_t p);
		out_word_t o;
		bit        z1, z2;
		longint    sum;
		sum = charge_potential(plus_coef_r, plus_center_r, p, z1);
		sum += charge_potential(minus_coef_r, minus_center_r, p, z2);
		o.saturated = z1 | z2;
		if (sum > 64'sh7FFF_FFFF) begin
			sum = 64'sh7FFF_FFFF;
			o.saturated = 1;
		end else if (sum < -64'sh8000_0000) begin
			sum = -64'sh8000_0000;
			o.saturated = 1;
		end
		o.potential = sum[31:0];
		return o;
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [62:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_PLUS_COEF:    plus_coef_r = val[31:0];
			REG_MINUS_COEF:   minus_coef_r = val[31:0];
			REG_PLUS_CENTER:  plus_center_r = val;
			REG_MINUS_CENTER: minus_center_r = val;
			REG_DECAY_RATE:   decay_r = val[31:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (130) @(posedge clk);
	endtask

	task automatic send(input in_word_t w, input bit typed, input out_word_t res);
		int gap;
		in_valid <= 1;
		in_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_q.push_back(typed ? res : dipole_potential(w));
		gap = 0;
		if (!calm)
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
				($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [62:0] grid_center(logic [9:0] x, logic [9:0] y, logic [9:0] z);
		return {11'(z), 10'd0, 11'(y), 10'd0, 11'(x), 10'd0};
	endfunction

	function automatic logic [62:0] rand_center();
		if ($urandom_range(0, 1))
			return grid_center(10'($urandom_range(1, 512)), 10'($urandom_range(1, 512)),
				10'($urandom_range(1, 512)));
		return 63'({$urandom, $urandom});
	endfunction

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
		endcase
	endfunction

	function automatic logic [31:0] rand_decay();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 1 << 22);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [9:0] near(logic [20:0] c);
		return 10'((c >> 10) + $urandom_range(0, 6) - 3);
	endfunction

	function automatic in_word_t rand_point();
		in_word_t    w;
		logic [62:0] c;
		int          r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			c = $urandom_range(0, 1) ? plus_center_r : minus_center_r;
			w.point_x = near(c[20:0]);
			w.point_y = near(c[41:21]);
			w.point_z = near(c[62:42]);
		end else if (r < 8) begin
			w.point_x = 10'($urandom_range(1, 512));
			w.point_y = 10'($urandom_range(1, 512));
			w.point_z = 10'($urandom_range(1, 512));
		end else begin
			w = 30'($urandom);
		end
		return w;
	endfunction

	always @(posedge clk) begin
		if (!calm && out_hold == 0) begin
			int r;
			r = $urandom_range(0, 99);
			if (r < 70) begin
				out_stall <= 0;
				out_hold <= $urandom_range(0, 20);
			end else if (r < 95) begin
				out_stall <= 1;
				out_hold <= $urandom_range(0, 3);
			end else begin
				out_stall <= 1;
				out_hold <= $urandom_range(10, 60);
			end
		end else if (calm) begin
			out_stall <= 0;
		end else begin
			out_hold <= out_hold - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: potential %h saturated %b",
						out_word.potential, out_word.saturated);
			end else begin
				out_word_t ex;
				ex = pending_q.pop_front();
				if (ex.potential !== out_word.potential || ex.saturated !== out_word.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word mismatch: expected %h/%b, got %h/%b",
							ex.potential, ex.saturated,
							out_word.potential, out_word.saturated);
				end
			end
		end
	end

	dir_row_t dir_tab [] = '{
		'{'{10'd0, 10'd0, 10'd0}, 1, '{32'sd0, 1'b1}},
		'{'{10'd1, 10'd1, 10'd1}, 1, '{32'sd0, 1'b0}},
		'{'{10'd1023, 10'd1023, 10'd1023}, 1, '{32'sd0, 1'b0}},
		'{'{10'd512, 10'd512, 10'd512}, 1, '{32'sd0, 1'b0}},
		'{'{10'd1, 10'd1, 10'd1}, 0, '{32'sd0, 1'b0}},
		'{'{10'd512, 10'd512, 10'd512}, 0, '{32'sd0, 1'b0}},
		'{'{10'd2, 10'd1, 10'd1}, 0, '{32'sd0, 1'b0}},
		'{'{10'd511, 10'd512, 10'd512}, 0, '{32'sd0, 1'b0}},
		'{'{10'd0, 10'd0, 10'd0}, 0, '{32'sd0, 1'b0}},
		'{'{10'd1023, 10'd1023, 10'd1023}, 0, '{32'sd0, 1'b0}},
		'{'{10'd256, 10'd1, 10'd512}, 0, '{32'sd0, 1'b0}},
		'{'{10'd1, 10'd512, 10'd1}, 0, '{32'sd0, 1'b0}},
		'{'{10'd3, 10'd3, 10'd3}, 0, '{32'sd0, 1'b0}},
		'{'{10'd1, 10'd1, 10'd2}, 0, '{32'sd0, 1'b0}}
	};

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_word = '0;
		out_stall = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 0;
		out_hold = 0;
		mismatches = 0;
		plus_coef_r = 0;
		minus_coef_r = 0;
		plus_center_r = 0;
		minus_center_r = 0;
		decay_r = 0;
		half_root[1] = int_root(64'h8000_0000_0000_0000);
		for (int i = 2; i <= EXP_BITS; i++)
			half_root[i] = int_root(half_root[i-1] << 32);
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (i == 4) begin
				drain();
				for (int j = 5; j < 8; j++)
					write_reg(IDX_W'(j), 63'({$urandom, $urandom}));
				write_reg(REG_PLUS_COEF, 63'h7FFF_FFFF);
				write_reg(REG_MINUS_COEF, 63'h8000_0000);
				write_reg(REG_PLUS_CENTER, grid_center(1, 1, 1));
				write_reg(REG_MINUS_CENTER, grid_center(512, 512, 512));
				write_reg(REG_DECAY_RATE, 63'h0);
			end
			if (i == 9) begin
				drain();
				write_reg(REG_MINUS_COEF, 63'h7FFF_FFFF);
				write_reg(REG_MINUS_CENTER, grid_center(2, 1, 1));
				write_reg(REG_DECAY_RATE, 63'hFFFF_FFFF);
			end
			send(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			calm = (ph == 3);
			write_reg(REG_PLUS_COEF, 63'(rand_coef()));
			write_reg(REG_MINUS_COEF, 63'(rand_coef()));
			write_reg(REG_PLUS_CENTER, rand_center());
			write_reg(REG_MINUS_CENTER, rand_center());
			write_reg(REG_DECAY_RATE, 63'(rand_decay()));
			for (int k = 0; k < 220; k++)
				send(rand_point(), 0, '0);
		end
		in_valid <= 0;
		calm = 0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (130) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
